// File: design/lfpd_pkg.sv
// lfpd_pkg: shared types, sensor pattern codes, register indexes and reset values
// for the line follower pid drive; no dependencies
package lfpd_pkg;

    localparam int PAT_W      = 5;
    localparam int ERR_W      = 5;
    localparam int SUM_W      = 18;
    localparam int STRAIGHT_W = 10;
    localparam int DRIVE_W    = 8;
    localparam int GAIN_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef logic [PAT_W-1:0]        pattern_t;
    typedef logic signed [ERR_W-1:0] err_t;

    typedef struct packed {
        logic found;
        err_t err;
    } decode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_SPEED         = 3'd0,
        CFG_MIN_DRIVE          = 3'd1,
        CFG_MAX_DRIVE          = 3'd2,
        CFG_BOOST_SPEED        = 3'd3,
        CFG_STRAIGHT_THRESHOLD = 3'd4,
        CFG_GAIN_P             = 3'd5,
        CFG_GAIN_I             = 3'd6,
        CFG_GAIN_D             = 3'd7
    } cfg_index_t;

    localparam pattern_t PAT_CENTER      = 5'h04;
    localparam pattern_t PAT_RIGHT_HALF  = 5'h0C;
    localparam pattern_t PAT_RIGHT_INNER = 5'h08;
    localparam pattern_t PAT_RIGHT_WIDE  = 5'h18;
    localparam pattern_t PAT_RIGHT_OUTER = 5'h10;
    localparam pattern_t PAT_LEFT_HALF   = 5'h06;
    localparam pattern_t PAT_LEFT_INNER  = 5'h02;
    localparam pattern_t PAT_LEFT_WIDE   = 5'h03;
    localparam pattern_t PAT_LEFT_OUTER  = 5'h01;

    localparam err_t LOST_ERROR = 5'sd12;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 18'sh1FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 18'sh20000;

    localparam logic [STRAIGHT_W-1:0] STRAIGHT_MAX   = 10'd1023;
    localparam logic [STRAIGHT_W-1:0] STRAIGHT_RESET = 10'd100;

    localparam logic [DRIVE_W-1:0]    BASE_SPEED_RESET  = 8'd100;
    localparam logic [DRIVE_W-1:0]    MIN_DRIVE_RESET   = 8'd30;
    localparam logic [DRIVE_W-1:0]    MAX_DRIVE_RESET   = 8'd210;
    localparam logic [DRIVE_W-1:0]    BOOST_SPEED_RESET = 8'd80;
    localparam logic [STRAIGHT_W-1:0] THRESHOLD_RESET   = 10'd500;
    localparam logic [GAIN_W-1:0]     GAIN_P_RESET      = 12'd1536;
    localparam logic [GAIN_W-1:0]     GAIN_I_RESET      = 12'd20;
    localparam logic [GAIN_W-1:0]     GAIN_D_RESET      = 12'd13;

endpackage

// File: design/line_follower_pid_drive.sv
// line_follower_pid_drive: top level, pid steering of two wheel drives from line samples
// depends on lfpd_pkg and lfpd_decode
//
// One sensor sample is taken per clock and each produces one result, at a sustained rate
// of one item per cycle while no stall holds it. The first stage decodes the sample and
// updates the integral, sample window and straight-run counters as the request is
// accepted; the second forms the three gain products; the third sums, truncates toward
// zero, applies boost and clamps into the output register. Register writes are taken
// at any time through cfg_valid/cfg_ready and must only be made while the block is idle.
module line_follower_pid_drive
#(
    parameter int INTEGRAL_WINDOW = 4000
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  sensor_pattern,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  left_drive,
    output logic [7:0]  right_drive,
    output logic signed [4:0] position_error,
    output logic        line_found,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int CNT_W = $clog2(INTEGRAL_WINDOW + 1);
    localparam int D_W   = lfpd_pkg::ERR_W + 1;
    localparam int PP_W  = 18;
    localparam int PI_W  = 31;
    localparam int PD_W  = 19;
    localparam int PID_W = 32;
    localparam int TQ_W  = PID_W - 8;

    // configuration
    logic [7:0]  base_speed_reg, min_drive_reg, max_drive_reg, boost_speed_reg;
    logic [9:0]  straight_threshold_reg;
    logic [11:0] gain_p_reg, gain_i_reg, gain_d_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_speed_reg         <= lfpd_pkg::BASE_SPEED_RESET;
            min_drive_reg          <= lfpd_pkg::MIN_DRIVE_RESET;
            max_drive_reg          <= lfpd_pkg::MAX_DRIVE_RESET;
            boost_speed_reg        <= lfpd_pkg::BOOST_SPEED_RESET;
            straight_threshold_reg <= lfpd_pkg::THRESHOLD_RESET;
            gain_p_reg             <= lfpd_pkg::GAIN_P_RESET;
            gain_i_reg             <= lfpd_pkg::GAIN_I_RESET;
            gain_d_reg             <= lfpd_pkg::GAIN_D_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lfpd_pkg::cfg_index_t'(cfg_index))
                lfpd_pkg::CFG_BASE_SPEED:         base_speed_reg <= cfg_data[7:0];
                lfpd_pkg::CFG_MIN_DRIVE:          min_drive_reg <= cfg_data[7:0];
                lfpd_pkg::CFG_MAX_DRIVE:          max_drive_reg <= cfg_data[7:0];
                lfpd_pkg::CFG_BOOST_SPEED:        boost_speed_reg <= cfg_data[7:0];
                lfpd_pkg::CFG_STRAIGHT_THRESHOLD: straight_threshold_reg <= cfg_data[9:0];
                lfpd_pkg::CFG_GAIN_P:             gain_p_reg <= cfg_data;
                lfpd_pkg::CFG_GAIN_I:             gain_i_reg <= cfg_data;
                lfpd_pkg::CFG_GAIN_D:             gain_d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic adv3, free2, accept;

    assign adv3     = !s3_valid_reg || !out_stall;
    assign free2    = !s2_valid_reg || adv3;
    assign in_stall = s1_valid_reg && !free2;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (free2)
                s2_valid_reg <= s1_valid_reg;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1: decode and controller state
    lfpd_pkg::decode_t dec;

    lfpd_decode u_decode
    (
        .pattern (sensor_pattern),
        .decoded (dec)
    );

    lfpd_pkg::err_t                  prior_error_reg;
    logic signed [lfpd_pkg::SUM_W-1:0] error_sum_reg, error_sum_next;
    logic [CNT_W-1:0]                sample_count_reg, sample_count_next;
    logic [lfpd_pkg::STRAIGHT_W-1:0] straight_count_reg, straight_count_next;

    logic                            centred, window_clear;
    logic [CNT_W:0]                  count_inc;
    logic signed [lfpd_pkg::SUM_W-1:0] sum_base;
    logic signed [lfpd_pkg::SUM_W:0]   sum_wide;
    logic signed [D_W-1:0]           diff_next;

    always_comb
    begin
        centred   = dec.found && (dec.err == 5'sd0);
        count_inc = {1'b0, sample_count_reg} + {{CNT_W{1'b0}}, 1'b1};
        window_clear = count_inc > (CNT_W+1)'(INTEGRAL_WINDOW);
        sample_count_next = window_clear ? '0 : count_inc[CNT_W-1:0];

        straight_count_next = straight_count_reg;
        if (dec.found)
        begin
            if (!centred)
                straight_count_next = '0;
            else if (straight_count_reg != lfpd_pkg::STRAIGHT_MAX)
                straight_count_next = straight_count_reg + 10'd1;
        end

        sum_base = (centred || window_clear) ? '0 : error_sum_reg;
        sum_wide = {sum_base[lfpd_pkg::SUM_W-1], sum_base}
                 + {{(lfpd_pkg::SUM_W+1-lfpd_pkg::ERR_W){dec.err[lfpd_pkg::ERR_W-1]}},
                    dec.err};
        if (sum_wide[lfpd_pkg::SUM_W] != sum_wide[lfpd_pkg::SUM_W-1])
            error_sum_next = sum_wide[lfpd_pkg::SUM_W] ? lfpd_pkg::SUM_MIN
                                                       : lfpd_pkg::SUM_MAX;
        else
            error_sum_next = sum_wide[lfpd_pkg::SUM_W-1:0];

        diff_next = {dec.err[lfpd_pkg::ERR_W-1], dec.err}
                  - {prior_error_reg[lfpd_pkg::ERR_W-1], prior_error_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_error_reg    <= '0;
            error_sum_reg      <= '0;
            sample_count_reg   <= '0;
            straight_count_reg <= lfpd_pkg::STRAIGHT_RESET;
        end
        else if (accept)
        begin
            prior_error_reg    <= dec.err;
            error_sum_reg      <= error_sum_next;
            sample_count_reg   <= sample_count_next;
            straight_count_reg <= straight_count_next;
        end
    end

    lfpd_pkg::err_t                  s1_err_reg;
    logic                            s1_found_reg, s1_boost_reg;
    logic signed [D_W-1:0]           s1_diff_reg;
    logic signed [lfpd_pkg::SUM_W-1:0] s1_sum_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_err_reg   <= dec.err;
            s1_found_reg <= dec.found;
            s1_boost_reg <= straight_count_next >= straight_threshold_reg;
            s1_diff_reg  <= diff_next;
            s1_sum_reg   <= error_sum_next;
        end
    end

    // stage 2: gain products
    logic signed [PP_W-1:0] prod_p_reg, prod_p_next, gp_ext, ep_ext;
    logic signed [PI_W-1:0] prod_i_reg, prod_i_next, gi_ext, si_ext;
    logic signed [PD_W-1:0] prod_d_reg, prod_d_next, gd_ext, dd_ext;
    lfpd_pkg::err_t         s2_err_reg;
    logic                   s2_found_reg, s2_boost_reg;

    always_comb
    begin
        gp_ext = {{(PP_W-12){1'b0}}, gain_p_reg};
        ep_ext = {{(PP_W-lfpd_pkg::ERR_W){s1_err_reg[lfpd_pkg::ERR_W-1]}}, s1_err_reg};
        gi_ext = {{(PI_W-12){1'b0}}, gain_i_reg};
        si_ext = {{(PI_W-lfpd_pkg::SUM_W){s1_sum_reg[lfpd_pkg::SUM_W-1]}}, s1_sum_reg};
        gd_ext = {{(PD_W-12){1'b0}}, gain_d_reg};
        dd_ext = {{(PD_W-D_W){s1_diff_reg[D_W-1]}}, s1_diff_reg};
        prod_p_next = gp_ext * ep_ext;
        prod_i_next = gi_ext * si_ext;
        prod_d_next = gd_ext * dd_ext;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && free2)
        begin
            prod_p_reg   <= prod_p_next;
            prod_i_reg   <= prod_i_next;
            prod_d_reg   <= prod_d_next;
            s2_err_reg   <= s1_err_reg;
            s2_found_reg <= s1_found_reg;
            s2_boost_reg <= s1_boost_reg;
        end
    end

    // stage 3: sum, truncate toward zero, boost, clamp
    function automatic logic [7:0] clamp_drive
    (
        input logic signed [TQ_W-1:0] v,
        input logic [7:0]             hi,
        input logic [7:0]             lo
    );
        logic signed [TQ_W-1:0] r;
        r = v;
        if (r > $signed({{(TQ_W-8){1'b0}}, hi}))
            r = $signed({{(TQ_W-8){1'b0}}, hi});
        if (r < $signed({{(TQ_W-8){1'b0}}, lo}))
            r = $signed({{(TQ_W-8){1'b0}}, lo});
        return r[7:0];
    endfunction

    logic signed [PID_W-1:0] pid, base_q, left_q, right_q, left_adj, right_adj;
    logic signed [TQ_W-1:0]  left_t, right_t;
    logic [7:0]              left_next, right_next;

    always_comb
    begin
        pid = {{(PID_W-PP_W){prod_p_reg[PP_W-1]}}, prod_p_reg}
            + {{(PID_W-PI_W){prod_i_reg[PI_W-1]}}, prod_i_reg}
            + {{(PID_W-PD_W){prod_d_reg[PD_W-1]}}, prod_d_reg};
        base_q  = {{(PID_W-16){1'b0}}, base_speed_reg, 8'd0};
        left_q  = base_q + pid;
        right_q = base_q - pid;
        left_adj  = left_q + (left_q[PID_W-1] ? 32'sd255 : 32'sd0);
        right_adj = right_q + (right_q[PID_W-1] ? 32'sd255 : 32'sd0);
        left_t  = left_adj[PID_W-1:8];
        right_t = right_adj[PID_W-1:8];
        if (s2_boost_reg)
        begin
            left_t  = $signed({{(TQ_W-8){1'b0}}, boost_speed_reg});
            right_t = left_t;
        end
        left_next  = clamp_drive(left_t, max_drive_reg, min_drive_reg);
        right_next = clamp_drive(right_t, max_drive_reg, min_drive_reg);
    end

    logic [7:0]     left_drive_reg, right_drive_reg;
    lfpd_pkg::err_t position_error_reg;
    logic           line_found_reg;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && adv3)
        begin
            left_drive_reg     <= left_next;
            right_drive_reg    <= right_next;
            position_error_reg <= s2_err_reg;
            line_found_reg     <= s2_found_reg;
        end
    end

    assign out_valid      = s3_valid_reg;
    assign left_drive     = left_drive_reg;
    assign right_drive    = right_drive_reg;
    assign position_error = position_error_reg;
    assign line_found     = line_found_reg;

    // checks
    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sample_count_reg <= CNT_W'(INTEGRAL_WINDOW))
        else $error("sample window counter past its limit");

    a_centre_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sensor_pattern == lfpd_pkg::PAT_CENTER) |=> error_sum_reg == '0)
        else $error("centred sample did not clear the integral");

    a_lost_holds_run: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !dec.found) |=> $stable(straight_count_reg))
        else $error("lost line changed the straight count");

    a_lost_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !line_found) |-> position_error == lfpd_pkg::LOST_ERROR)
        else $error("lost line result without the lost code");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s3_valid_reg && out_stall) |=> s2_valid_reg && s3_valid_reg)
        else $error("stalled request dropped from the pipeline");

endmodule

// File: design/lfpd_decode.sv
// lfpd_decode: maps a 5-bit line sensor pattern to a signed position error
// depends on lfpd_pkg
module lfpd_decode
(
    input  lfpd_pkg::pattern_t pattern,
    output lfpd_pkg::decode_t  decoded
);

    always_comb
    begin
        decoded.found = 1'b1;
        case (pattern)
            lfpd_pkg::PAT_CENTER:      decoded.err = 5'sd0;
            lfpd_pkg::PAT_RIGHT_HALF:  decoded.err = -5'sd1;
            lfpd_pkg::PAT_RIGHT_INNER: decoded.err = -5'sd3;
            lfpd_pkg::PAT_RIGHT_WIDE:  decoded.err = -5'sd5;
            lfpd_pkg::PAT_RIGHT_OUTER: decoded.err = -5'sd9;
            lfpd_pkg::PAT_LEFT_HALF:   decoded.err = 5'sd1;
            lfpd_pkg::PAT_LEFT_INNER:  decoded.err = 5'sd3;
            lfpd_pkg::PAT_LEFT_WIDE:   decoded.err = 5'sd5;
            lfpd_pkg::PAT_LEFT_OUTER:  decoded.err = 5'sd9;
            default:
            begin
                decoded.found = 1'b0;
                decoded.err   = lfpd_pkg::LOST_ERROR;
            end
        endcase
    end

endmodule
